// ===== sv/mbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbaf_pkg
// Shared types, character codes and helpers for the Modbus ASCII framer.
// ----------------------------------------------------------------------------
package mbaf_pkg;

	localparam int MaxChars = 13;
	localparam int CharW    = 7;
	localparam int CntW     = $clog2(MaxChars + 1);
	localparam int IdxW     = $clog2(MaxChars);

	localparam logic [CharW-1:0] CHAR_COLON = 7'h3a;
	localparam logic [CharW-1:0] CHAR_CR    = 7'h0d;
	localparam logic [CharW-1:0] CHAR_LF    = 7'h0a;
	localparam logic [CharW-1:0] CHAR_ZERO  = 7'h30;
	// 'A' minus ten, so that a nibble of ten maps onto 'A'
	localparam logic [CharW-1:0] CHAR_ALPHA_BASE = 7'h37;

	localparam logic [CntW-1:0] HEADER_CHARS  = 4'd5;
	localparam logic [CntW-1:0] DATA_CHARS    = 4'd4;
	localparam logic [CntW-1:0] TRAILER_CHARS = 4'd4;

	localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

	typedef struct packed {
		logic [7:0]  function_code;
		logic [15:0] data_word;
		logic        first_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [CharW-1:0] ascii_char;
		logic             run_end;
	} out_item_t;

	typedef logic [MaxChars-1:0][CharW-1:0] char_vec_t;

	// Uppercase hex digit for one nibble
	function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
		logic [CharW-1:0] ext;
		ext = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_char = CHAR_ZERO + ext;
		end else begin
			hex_char = CHAR_ALPHA_BASE + ext;
		end
	endfunction

endpackage

// ===== sv/mbaf_build.sv =====
// ----------------------------------------------------------------------------
// mbaf_build
// Lays out the characters caused by one word and updates the running sum.
// ----------------------------------------------------------------------------
module mbaf_build (
	input  mbaf_pkg::in_item_t                item,
	input  logic [7:0]                        slave_address,
	input  logic [7:0]                        sum_cur,
	output mbaf_pkg::char_vec_t               chars,
	output logic [mbaf_pkg::CntW-1:0]         char_cnt,
	output logic [7:0]                        sum_next
);

	logic [7:0] base_sum;
	logic [7:0] word_sum;
	logic [7:0] lrc;
	logic [3:0] data_nib [4];
	logic [3:0] lrc_hi;
	logic [3:0] lrc_lo;

	assign base_sum = item.first_word ? (slave_address + item.function_code) : sum_cur;
	assign word_sum = base_sum + item.data_word[15:8] + item.data_word[7:0];
	assign lrc      = 8'h00 - word_sum;
	assign sum_next = item.last_word ? 8'h00 : word_sum;

	assign data_nib[0] = item.data_word[15:12];
	assign data_nib[1] = item.data_word[11:8];
	assign data_nib[2] = item.data_word[7:4];
	assign data_nib[3] = item.data_word[3:0];
	assign lrc_hi      = lrc[7:4];
	assign lrc_lo      = lrc[3:0];

	assign char_cnt = mbaf_pkg::DATA_CHARS
		+ (item.first_word ? mbaf_pkg::HEADER_CHARS : '0)
		+ (item.last_word ? mbaf_pkg::TRAILER_CHARS : '0);

	always_comb begin
		chars = '0;
		if (item.first_word) begin
			chars[0]  = mbaf_pkg::CHAR_COLON;
			chars[1]  = mbaf_pkg::hex_char(slave_address[7:4]);
			chars[2]  = mbaf_pkg::hex_char(slave_address[3:0]);
			chars[3]  = mbaf_pkg::hex_char(item.function_code[7:4]);
			chars[4]  = mbaf_pkg::hex_char(item.function_code[3:0]);
			chars[5]  = mbaf_pkg::hex_char(data_nib[0]);
			chars[6]  = mbaf_pkg::hex_char(data_nib[1]);
			chars[7]  = mbaf_pkg::hex_char(data_nib[2]);
			chars[8]  = mbaf_pkg::hex_char(data_nib[3]);
			chars[9]  = mbaf_pkg::hex_char(lrc_hi);
			chars[10] = mbaf_pkg::hex_char(lrc_lo);
			chars[11] = mbaf_pkg::CHAR_CR;
			chars[12] = mbaf_pkg::CHAR_LF;
		end else begin
			chars[0] = mbaf_pkg::hex_char(data_nib[0]);
			chars[1] = mbaf_pkg::hex_char(data_nib[1]);
			chars[2] = mbaf_pkg::hex_char(data_nib[2]);
			chars[3] = mbaf_pkg::hex_char(data_nib[3]);
			chars[4] = mbaf_pkg::hex_char(lrc_hi);
			chars[5] = mbaf_pkg::hex_char(lrc_lo);
			chars[6] = mbaf_pkg::CHAR_CR;
			chars[7] = mbaf_pkg::CHAR_LF;
		end
	end

endmodule

// ===== sv/mbaf_emit.sv =====
// ----------------------------------------------------------------------------
// mbaf_emit
// Holds one word's characters and sends them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module mbaf_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  mbaf_pkg::char_vec_t           load_chars,
	input  logic [mbaf_pkg::CntW-1:0]     load_cnt,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mbaf_pkg::out_item_t           out_data
);

	mbaf_pkg::char_vec_t            chars_s1;
	logic [mbaf_pkg::CntW-1:0]      cnt_s1;
	logic                           buf_valid_s1;
	logic [mbaf_pkg::CntW-1:0]      idx_q;
	logic                           out_valid_q;
	mbaf_pkg::out_item_t            out_q;
	logic                           advance;
	logic                           at_last;

	assign advance = buf_valid_s1 && (!out_valid_q || !out_stall);
	assign at_last = (idx_q == cnt_s1 - 4'd1);
	// buffer stays occupied unless its final character moves out this cycle
	assign busy    = buf_valid_s1 && !(advance && at_last);

	always_ff @(posedge clk) begin
		if (load) begin
			chars_s1 <= load_chars;
			cnt_s1   <= load_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (load) begin
				buf_valid_s1 <= 1'b1;
				idx_q        <= '0;
			end else if (advance) begin
				if (at_last) begin
					buf_valid_s1 <= 1'b0;
					idx_q        <= '0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= buf_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.ascii_char <= chars_s1[idx_q[mbaf_pkg::IdxW-1:0]];
			out_q.run_end    <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("buffer reloaded while characters remain");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		buf_valid_s1 |-> (idx_q < cnt_s1))
		else $error("character index past count");

	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		buf_valid_s1 |-> (cnt_s1 == 4'd4 || cnt_s1 == 4'd8 || cnt_s1 == 4'd9
			|| cnt_s1 == 4'd13))
		else $error("illegal character count");

	a_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && at_last && !load) |=> !buf_valid_s1)
		else $error("buffer not released after final character");

endmodule

// ===== sv/modbus_ascii_request_framer_top.sv =====
// ----------------------------------------------------------------------------
// modbus_ascii_request_framer_top
// Modbus ASCII request framer: data words in, frame characters out, with LRC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one 16-bit data word
//   per transfer, with function code and first/last frame marks. A word
//   marked first opens the frame with ':', address and function code; a
//   word marked last closes it with the LRC, CR and LF.
//   Output channel (out_valid / out_stall / out_data) gives one 7-bit ASCII
//   character per transfer; run_end flags the last character of each word.
//   cfg_wr_en / cfg_wr_data write the slave address; write only when idle.
// Timing:
//   A word's characters are laid out in one pass and held in a 13-entry
//   character buffer; after accept, the first character passes from the
//   buffer to the output register. The buffer drains one character per
//   cycle while out_stall is low, and a word gives 4, 8, 9 or 13 characters;
//   the next word is accepted in the cycle its predecessor's last character
//   moves to the output register, giving back-to-back output with no gaps.
// Reset:
//   arst_n clears the channels and the running sum; address returns to 1.
// Stall:
//   out_stall holds the output register and the buffer; in_stall rises as
//   soon as the buffer cannot take the next word.
// ----------------------------------------------------------------------------
module modbus_ascii_request_framer_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbaf_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mbaf_pkg::out_item_t  out_data
);

	logic [7:0]                   slave_address_q;
	logic [7:0]                   lrc_sum_q;
	logic                         in_accept;
	logic                         emit_busy;
	mbaf_pkg::char_vec_t          build_chars;
	logic [mbaf_pkg::CntW-1:0]    build_cnt;
	logic [7:0]                   build_sum;

	// Accept whenever the character buffer is free or frees this cycle
	assign in_stall  = emit_busy;
	assign in_accept = in_valid && !emit_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mbaf_pkg::SLAVE_ADDRESS_RESET;
		end else if (cfg_wr_en) begin
			slave_address_q <= cfg_wr_data;
		end
	end

	// Running frame sum: restarts on a first word, clears after a last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrc_sum_q <= 8'h00;
		end else if (in_accept) begin
			lrc_sum_q <= build_sum;
		end
	end

	mbaf_build u_build (
		.item          (in_data),
		.slave_address (slave_address_q),
		.sum_cur       (lrc_sum_q),
		.chars         (build_chars),
		.char_cnt      (build_cnt),
		.sum_next      (build_sum)
	);

	mbaf_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_accept),
		.load_chars (build_chars),
		.load_cnt   (build_cnt),
		.busy       (emit_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
